### design/xor_checked_frame_validator_defines.svh
// Assertion macros used by the checker file.
`ifndef XOR_CHECKED_FRAME_VALIDATOR_DEFINES_SVH
`define XOR_CHECKED_FRAME_VALIDATOR_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define XCFV_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define XCFV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define XCFV_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### design/xcfv_pkg.sv
package xcfv_pkg;

   localparam int unsigned TYPE_LEN    = 5;
   localparam int unsigned COMMA_POS   = 6;
   localparam int unsigned INDEX_MAX   = 7;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [7:0] START_CHAR_RESET = 8'h24;
   localparam logic [7:0] CHECK_CHAR_RESET = 8'h2A;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_CHAR = 1'b0,
      CSR_CHECK_CHAR = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_START = 2'd1,
      ST_SUM_ERR   = 2'd2,
      ST_TYPE_ERR  = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [39:0] sentence_id;
      logic [7:0]  computed_sum;
      logic [7:0]  received_sum;
   } rsp_type;

   // Framing characters handed from the register block to the tracker.
   typedef struct packed {
      logic [7:0] start_char;
      logic [7:0] check_char;
   } csr_type;

endpackage

### design/xcfv_track.sv
module xcfv_track
   import xcfv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_accept,
   input  req_type in_word,
   input  csr_type csr,
   output logic    res_valid,
   output rsp_type res_word
);

   localparam logic [7:0] COMMA = 8'h2C;

   typedef enum logic [1:0] {PH_START, PH_SPAN, PH_HEX, PH_TAIL} phase_type;
   typedef enum logic [1:0] {CM_NONE, CM_GOOD, CM_BAD} comma_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  xor_ff, xor_in;
   logic [39:0] type_ff, type_in;
   comma_type   comma_ff, comma_in;
   logic [7:0]  hex_ff, hex_in;
   logic [1:0]  hcnt_ff, hcnt_in;
   logic        hbad_ff, hbad_in;
   logic        sbad_ff, sbad_in;
   logic [4:0]  nib;
   logic        digits_ok;
   rsp_type     res;

   // {not_hex, value}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
      return r;
   endfunction

   assign nib = hex_nibble(in_word.data_byte);

   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      type_in  = type_ff;
      comma_in = comma_ff;
      hex_in   = hex_ff;
      hcnt_in  = hcnt_ff;
      hbad_in  = hbad_ff;
      sbad_in  = sbad_ff;
      idx_in   = (idx_ff < 3'(INDEX_MAX)) ? idx_ff + 3'd1 : 3'(INDEX_MAX);

      if (phase_ff == PH_START) begin
         sbad_in  = (in_word.data_byte != csr.start_char);
         phase_in = PH_SPAN;
      end else begin
         for (int k = 0; k < TYPE_LEN; k++) begin
            if (idx_ff == 3'(k + 1)) begin
               type_in[8*(TYPE_LEN-1-k) +: 8] =
                  type_ff[8*(TYPE_LEN-1-k) +: 8] | in_word.data_byte;
            end
         end
         if (in_word.data_byte == COMMA && comma_ff == CM_NONE) begin
            comma_in = (idx_ff == 3'(COMMA_POS)) ? CM_GOOD : CM_BAD;
         end
         case (phase_ff)
            PH_SPAN: begin
               if (in_word.data_byte == csr.check_char) phase_in = PH_HEX;
               else xor_in = xor_ff ^ in_word.data_byte;
            end
            PH_HEX: begin
               if (nib[4]) hbad_in = 1'b1;
               hex_in  = {hex_ff[3:0], nib[4] ? 4'h0 : nib[3:0]};
               hcnt_in = hcnt_ff + 2'd1;
               if (hcnt_in >= 2'd2) phase_in = PH_TAIL;
            end
            default: ;
         endcase
      end

      // Result from the updated state
      digits_ok        = (phase_in == PH_TAIL) && !hbad_in;
      res.sentence_id  = type_in;
      res.computed_sum = xor_in;
      res.received_sum = digits_ok ? hex_in : 8'h00;
      if (sbad_in) begin
         res.status       = ST_BAD_START;
         res.sentence_id  = '0;
         res.computed_sum = '0;
         res.received_sum = '0;
      end else if (!digits_ok || hex_in != xor_in) begin
         res.status = ST_SUM_ERR;
      end else if (comma_in != CM_GOOD) begin
         res.status = ST_TYPE_ERR;
      end else begin
         res.status = ST_OK;
      end
   end

   assign res_valid = in_accept && in_word.last;
   assign res_word  = res;

   always_ff @(posedge clock) begin
      if (reset || (in_accept && in_word.last)) begin
         phase_ff <= PH_START;
         idx_ff   <= '0;
         xor_ff   <= '0;
         type_ff  <= '0;
         comma_ff <= CM_NONE;
         hex_ff   <= '0;
         hcnt_ff  <= '0;
         hbad_ff  <= 1'b0;
         sbad_ff  <= 1'b0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         xor_ff   <= xor_in;
         type_ff  <= type_in;
         comma_ff <= comma_in;
         hex_ff   <= hex_in;
         hcnt_ff  <= hcnt_in;
         hbad_ff  <= hbad_in;
         sbad_ff  <= sbad_in;
      end
   end

endmodule

### design/xcfv_outq.sv
module xcfv_outq
   import xcfv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_word,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    main_vld_ff, skid_vld_ff;
   rsp_type main_ff, skid_ff;
   logic    pop;

   assign pop         = main_vld_ff && rsp_ready;
   assign space       = !skid_vld_ff;
   assign rsp_valid   = main_vld_ff;
   assign rsp_payload = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (pop) begin
         if (skid_vld_ff) begin
            main_ff     <= skid_ff;
            skid_vld_ff <= 1'b0;
         end else if (push) begin
            main_ff <= push_word;
         end else begin
            main_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (!main_vld_ff) begin
            main_ff     <= push_word;
            main_vld_ff <= 1'b1;
         end else begin
            skid_ff     <= push_word;
            skid_vld_ff <= 1'b1;
         end
      end
   end

endmodule

### design/xor_checked_frame_validator.sv
// Channel  Direction  Handshake            Word
// req_     in         req_valid/req_ready  req_payload {data_byte, last}
// rsp_     out        rsp_valid/rsp_ready  rsp_payload {status, sentence_id, sums}
// csr_     in         csr_we               csr_index, csr_wdata (no read-back)
//
// One byte per cycle while req_ready is high. Message state updates at the
// edge a byte is taken; the verdict for a last byte enters the output buffer
// at that same edge and shows on rsp_ once it sits in the main word.
// A two-word output buffer (main plus skid) decouples the sides: req_ready
// drops only while both words wait on rsp_ready.
// Reset is synchronous, active high; it restores '$' and '*' and rearms.
module xor_checked_frame_validator
   import xcfv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_type csr_ff;
   logic    accept;
   logic    res_valid;
   rsp_type res_word;
   logic    space;

   // Framing characters; a write takes effect from the next byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_char <= START_CHAR_RESET;
         csr_ff.check_char <= CHECK_CHAR_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_CHAR: csr_ff.start_char <= csr_wdata;
            CSR_CHECK_CHAR: csr_ff.check_char <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = space;
   assign accept    = req_valid && req_ready;

   // Per-byte parser: running XOR, hex digits, type bytes, comma position.
   xcfv_track u_track (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_word   (req_payload),
      .csr       (csr_ff),
      .res_valid (res_valid),
      .res_word  (res_word)
   );

   // Result register with skid word.
   xcfv_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push        (res_valid),
      .push_word   (res_word),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### design/xcfv_checker.sv
`include "xor_checked_frame_validator_defines.svh"

module xcfv_checker
   import xcfv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_payload,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   `XCFV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled rsp word changed")

   `XCFV_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_valid, "rsp valid right after reset")

   `XCFV_ASSERT_NOW(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && req_payload.last), "result without a last word")

   `XCFV_ASSERT_NOW(a_bad_start_zero, clock, reset, rsp_valid && rsp_payload.status == ST_BAD_START, rsp_payload.sentence_id == '0 && rsp_payload.computed_sum == '0 && rsp_payload.received_sum == '0, "bad start fields not cleared")

   `XCFV_ASSERT_NOW(a_ok_sums, clock, reset, rsp_valid && rsp_payload.status == ST_OK, rsp_payload.computed_sum == rsp_payload.received_sum, "ok status with sum mismatch")

endmodule

bind xor_checked_frame_validator xcfv_checker u_xcfv_checker (.*);
